// ===== hdl/radio_event_tracker_assert.svh =====
// Assertion macros for the radio event tracker checker.
// Depends on nothing; included by files that assert.
`ifndef RADIO_EVENT_TRACKER_ASSERT_SVH
`define RADIO_EVENT_TRACKER_ASSERT_SVH

`define RET_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("radio_event_tracker assertion failed");

`define RET_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("radio_event_tracker assertion failed");

`endif

// ===== hdl/rat_pkg.sv =====
// Package of the radio event tracker: sizes, codes, word and record types.
// Depends on nothing.
`default_nettype none
package rat_pkg;
   localparam int SLOTS   = 32;
   localparam int SLOT_AW = $clog2(SLOTS);
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 35;

   localparam logic [1:0] MODE_START  = 2'd0;
   localparam logic [1:0] MODE_DETECT = 2'd1;
   localparam logic [1:0] MODE_RETIRE = 2'd2;

   localparam logic [2:0] KIND_MERGED  = 3'd0;
   localparam logic [2:0] KIND_CREATED = 3'd1;
   localparam logic [2:0] KIND_FULL    = 3'd2;
   localparam logic [2:0] KIND_FINISHED = 3'd3;
   localparam logic [2:0] KIND_SHORT   = 3'd4;
   localparam logic [2:0] KIND_DONE    = 3'd5;

   localparam logic CSR_END_DELAY  = 1'b0;
   localparam logic CSR_MIN_LENGTH = 1'b1;

   typedef struct packed {
      logic [1:0]         mode;
      logic [63:0]        time_ns;
      logic [31:0]        freq_start_khz;
      logic [31:0]        freq_end_khz;
      logic signed [7:0]  power;
   } req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [31:0]        entry_id;
      logic [63:0]        start_time_ns;
      logic [63:0]        end_time_ns;
      logic [31:0]        low_freq_khz;
      logic [31:0]        high_freq_khz;
      logic signed [7:0]  peak_power;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        id;
      logic [63:0]        first_time;
      logic [63:0]        last_time;
      logic [31:0]        low_freq;
      logic [31:0]        high_freq;
      logic signed [7:0]  power;
   } slot_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_DCHK,
      ST_RCHK
   } state_type;

   function automatic logic [31:0] centre_of(input logic [31:0] lo, input logic [31:0] hi);
      logic [31:0] w;
      begin
         w = hi - lo;
         centre_of = lo + {1'b0, w[31:1]};
      end
   endfunction
endpackage
`default_nettype wire

// ===== hdl/radio_event_tracker.sv =====
// Top level of the radio event tracker: slot table in one RAM, scan sequencer.
// Depends on rat_pkg and rat_ram.
//
// Channel  Ports                      Handshake
// req      start, busy, req           word taken when start and not busy
// rsp      rsp_valid, rsp             word shown for one cycle, always taken
// csr      csr_we, csr_index, csr_wdata   written when csr_we is high
//
// A start-frame word only sets the frame time and leaves the tracker idle. A detection
// computes its tolerance, then scans the live slots until a match or the last live slot,
// since the slot RAM gives one record per cycle. A frame end scans every live slot
// and shows one word per retired slot plus the frame-done word.
// Reset is synchronous; live slots are tracked by a fill count, so no clearing pass.
`default_nettype none
module radio_event_tracker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire rat_pkg::req_type req,
   output logic                  rsp_valid,
   output rat_pkg::rsp_type      rsp,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [31:0]      csr_wdata
);
   rat_pkg::state_type state_ff, state_in;
   logic [rat_pkg::CNT_W-1:0] idx_ff, idx_in, wr_ff, wr_in, count_ff, count_in;
   logic [31:0] next_id_ff, next_id_in;
   logic [63:0] frame_time_ff, frame_time_in;
   logic [31:0] delay_ff, minlen_ff;
   rat_pkg::req_type req_ff, req_in;
   logic [63:0] prod_ff, prod_in;
   rat_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic ram_we;
   logic [rat_pkg::SLOT_AW-1:0] ram_waddr, ram_raddr;
   rat_pkg::slot_type ram_wdata, slot;
   logic [$bits(rat_pkg::slot_type)-1:0] ram_rdata;

   logic accept, in_range, hit, expired, too_short;
   logic [31:0] det_w, det_c, slot_c, diff, tol;
   logic [rat_pkg::CNT_W-1:0] idx_next;
   rat_pkg::slot_type merged;

   rat_ram #(
      .WIDTH($bits(rat_pkg::slot_type)),
      .DEPTH(rat_pkg::SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr   (ram_raddr),
      .rdata_ff(ram_rdata)
   );

   assign accept   = start && (state_ff == rat_pkg::ST_IDLE);
   assign slot     = rat_pkg::slot_type'(ram_rdata);
   assign in_range = idx_ff < count_ff;
   assign idx_next = idx_ff + 1'b1;
   assign det_w    = req_ff.freq_end_khz - req_ff.freq_start_khz;
   assign det_c    = rat_pkg::centre_of(req_ff.freq_start_khz, req_ff.freq_end_khz);
   assign slot_c   = rat_pkg::centre_of(slot.low_freq, slot.high_freq);
   assign diff     = (det_c > slot_c) ? det_c - slot_c : slot_c - det_c;
   assign tol      = 32'(prod_ff >> rat_pkg::RECIP_SHIFT);
   assign hit      = in_range && (diff < tol);
   assign expired  = (frame_time_ff - slot.last_time) > {32'd0, delay_ff};
   assign too_short = (slot.last_time - slot.first_time) < {32'd0, minlen_ff};

   always_comb begin
      merged = slot;
      merged.last_time = frame_time_ff;
      if (slot.low_freq > req_ff.freq_start_khz) begin
         merged.low_freq = req_ff.freq_start_khz;
      end
      if (slot.high_freq < req_ff.freq_end_khz) begin
         merged.high_freq = req_ff.freq_end_khz;
      end
      if (slot.power < req_ff.power) begin
         merged.power = req_ff.power;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rat_pkg::ST_IDLE: begin
            if (accept && req.mode == rat_pkg::MODE_DETECT) begin
               state_in = rat_pkg::ST_CALC;
            end else if (accept && req.mode == rat_pkg::MODE_RETIRE) begin
               state_in = rat_pkg::ST_RCHK;
            end
         end
         rat_pkg::ST_CALC: state_in = rat_pkg::ST_DCHK;
         rat_pkg::ST_DCHK: begin
            if (hit || !in_range) begin
               state_in = rat_pkg::ST_IDLE;
            end
         end
         rat_pkg::ST_RCHK: begin
            if (!in_range) begin
               state_in = rat_pkg::ST_IDLE;
            end
         end
         default: state_in = rat_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = (state_ff != rat_pkg::ST_IDLE);
      rsp_valid = rsp_valid_ff;
      rsp       = rsp_ff;
   end

   always_comb begin
      idx_in        = idx_ff;
      wr_in         = wr_ff;
      count_in      = count_ff;
      next_id_in    = next_id_ff;
      frame_time_in = frame_time_ff;
      req_in        = req_ff;
      prod_in       = prod_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff[rat_pkg::SLOT_AW-1:0];
      ram_wdata     = merged;
      ram_raddr     = '0;
      case (state_ff)
         rat_pkg::ST_IDLE: begin
            idx_in = '0;
            wr_in  = '0;
            if (accept) begin
               req_in = req;
               if (req.mode == rat_pkg::MODE_START) begin
                  frame_time_in = req.time_ns;
               end
            end
         end
         rat_pkg::ST_CALC: begin
            prod_in = {32'd0, det_w} * {32'd0, rat_pkg::RECIP_TEN};
         end
         rat_pkg::ST_DCHK: begin
            ram_raddr = idx_next[rat_pkg::SLOT_AW-1:0];
            idx_in    = idx_next;
            if (hit) begin
               ram_we       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = '{rat_pkg::KIND_MERGED, merged.id, merged.first_time,
                                merged.last_time, merged.low_freq, merged.high_freq,
                                merged.power, 1'b1};
            end else if (!in_range) begin
               rsp_valid_in = 1'b1;
               if (count_ff == rat_pkg::CNT_W'(rat_pkg::SLOTS)) begin
                  rsp_in = '{rat_pkg::KIND_FULL, 32'd0, frame_time_ff, frame_time_ff,
                             req_ff.freq_start_khz, req_ff.freq_end_khz,
                             req_ff.power, 1'b1};
               end else begin
                  ram_we     = 1'b1;
                  ram_waddr  = count_ff[rat_pkg::SLOT_AW-1:0];
                  ram_wdata  = '{next_id_ff, frame_time_ff, frame_time_ff,
                                 req_ff.freq_start_khz, req_ff.freq_end_khz,
                                 req_ff.power};
                  count_in   = count_ff + 1'b1;
                  next_id_in = next_id_ff + 32'd1;
                  rsp_in     = '{rat_pkg::KIND_CREATED, next_id_ff, frame_time_ff,
                                 frame_time_ff, req_ff.freq_start_khz,
                                 req_ff.freq_end_khz, req_ff.power, 1'b1};
               end
            end
         end
         rat_pkg::ST_RCHK: begin
            ram_raddr = idx_next[rat_pkg::SLOT_AW-1:0];
            idx_in    = idx_next;
            if (in_range) begin
               if (expired) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{too_short ? rat_pkg::KIND_SHORT : rat_pkg::KIND_FINISHED,
                             slot.id, slot.first_time, slot.last_time, slot.low_freq,
                             slot.high_freq, slot.power, 1'b0};
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = wr_ff[rat_pkg::SLOT_AW-1:0];
                  ram_wdata = slot;
                  wr_in     = wr_ff + 1'b1;
               end
            end else begin
               count_in      = wr_ff;
               frame_time_in = '0;
               rsp_valid_in  = 1'b1;
               rsp_in        = '{rat_pkg::KIND_DONE, 32'd0, 64'd0, 64'd0, 32'd0, 32'd0,
                                 8'sd0, 1'b1};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rat_pkg::ST_IDLE;
         idx_ff        <= '0;
         wr_ff         <= '0;
         count_ff      <= '0;
         next_id_ff    <= '0;
         frame_time_ff <= '0;
         delay_ff      <= '0;
         minlen_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         wr_ff         <= wr_in;
         count_ff      <= count_in;
         next_id_ff    <= next_id_in;
         frame_time_ff <= frame_time_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we && csr_index == rat_pkg::CSR_END_DELAY) begin
            delay_ff <= csr_wdata;
         end
         if (csr_we && csr_index == rat_pkg::CSR_MIN_LENGTH) begin
            minlen_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end
endmodule
`default_nettype wire

// ===== hdl/rat_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing.
`default_nettype none
module rat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== hdl/rat_checker.sv =====
// Port-level checker for the radio event tracker, bound to the top level.
// Depends on rat_pkg and radio_event_tracker_assert.svh.
`default_nettype none
`include "radio_event_tracker_assert.svh"
module rat_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire rat_pkg::req_type req,
   input wire logic             rsp_valid,
   input wire rat_pkg::rsp_type rsp
);
   logic work_req;

   assign work_req = start && !busy &&
                     (req.mode == rat_pkg::MODE_DETECT || req.mode == rat_pkg::MODE_RETIRE);

   `RET_ASSERT_NEXT(a_last_frees, clock, reset, rsp_valid && rsp.last && !start, !busy)
   `RET_ASSERT_NEXT(a_work_busy, clock, reset, work_req, busy)
   `RET_ASSERT_NOW(a_rsp_in_work, clock, reset, rsp_valid, $past(busy))
   `RET_ASSERT_NOW(a_done_last, clock, reset, rsp_valid && rsp.kind == rat_pkg::KIND_DONE, rsp.last)
endmodule

bind radio_event_tracker rat_checker u_rat_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req      (req),
   .rsp_valid(rsp_valid),
   .rsp      (rsp)
);
`default_nettype wire

// ===== test/tb.sv =====
// Testbench of the radio event tracker: directed and random frames checked
// against a behavioral model of the slot table. Depends on rat_pkg and the RTL.
module tb;
   localparam int LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   rat_pkg::req_type req = '0;
   logic rsp_valid;
   rat_pkg::rsp_type rsp;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [31:0] csr_wdata = '0;

   radio_event_tracker dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Tracker state as the model sees it.
   rat_pkg::slot_type table_q[$];
   logic [31:0] next_id;
   logic [63:0] frame_time;
   logic [31:0] end_delay;
   logic [31:0] min_length;
   rat_pkg::rsp_type expected_words[$];
   int failures = 0;
   int send_gap = 0;
   int cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      rat_pkg::rsp_type exp_w;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word kind=%0d", rsp.kind);
            failures++;
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp.kind !== exp_w.kind) begin
               $error("kind exp %0d got %0d", exp_w.kind, rsp.kind); failures++;
            end
            if (rsp.entry_id !== exp_w.entry_id) begin
               $error("entry_id exp %0h got %0h", exp_w.entry_id, rsp.entry_id);
               failures++;
            end
            if (rsp.start_time_ns !== exp_w.start_time_ns) begin
               $error("start_time_ns exp %0h got %0h", exp_w.start_time_ns,
                  rsp.start_time_ns);
               failures++;
            end
            if (rsp.end_time_ns !== exp_w.end_time_ns) begin
               $error("end_time_ns exp %0h got %0h", exp_w.end_time_ns, rsp.end_time_ns);
               failures++;
            end
            if (rsp.low_freq_khz !== exp_w.low_freq_khz) begin
               $error("low_freq_khz exp %0h got %0h", exp_w.low_freq_khz,
                  rsp.low_freq_khz);
               failures++;
            end
            if (rsp.high_freq_khz !== exp_w.high_freq_khz) begin
               $error("high_freq_khz exp %0h got %0h", exp_w.high_freq_khz,
                  rsp.high_freq_khz);
               failures++;
            end
            if (rsp.peak_power !== exp_w.peak_power) begin
               $error("peak_power exp %0d got %0d", exp_w.peak_power, rsp.peak_power);
               failures++;
            end
            if (rsp.last !== exp_w.last) begin
               $error("last exp %0b got %0b", exp_w.last, rsp.last); failures++;
            end
         end
      end
   end

   function automatic logic [31:0] mid_freq(logic [31:0] lo, logic [31:0] hi);
      logic [31:0] w;
      w = hi - lo;
      return lo + (w >> 1);
   endfunction

   function automatic rat_pkg::rsp_type slot_word(logic [2:0] k, rat_pkg::slot_type e);
      rat_pkg::rsp_type r;
      r.kind = k;
      r.entry_id = e.id;
      r.start_time_ns = e.first_time;
      r.end_time_ns = e.last_time;
      r.low_freq_khz = e.low_freq;
      r.high_freq_khz = e.high_freq;
      r.peak_power = e.power;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic track_word(rat_pkg::req_type w);
      logic [31:0] width, c, ec, d, tol;
      logic [63:0] wide;
      rat_pkg::slot_type e;
      rat_pkg::slot_type kept[$];
      rat_pkg::rsp_type r;
      bit hit;
      hit = 0;
      if (w.mode == rat_pkg::MODE_START) begin
         frame_time = w.time_ns;
      end else if (w.mode == rat_pkg::MODE_DETECT) begin
         width = w.freq_end_khz - w.freq_start_khz;
         c = mid_freq(w.freq_start_khz, w.freq_end_khz);
         wide = {32'd0, width} * 64'd10;
         tol = 32'(wide / 64'd100);
         foreach (table_q[i]) begin
            if (!hit) begin
               ec = mid_freq(table_q[i].low_freq, table_q[i].high_freq);
               d = (c > ec) ? c - ec : ec - c;
               if (d < tol) begin
                  hit = 1;
                  table_q[i].last_time = frame_time;
                  if (table_q[i].low_freq > w.freq_start_khz)
                     table_q[i].low_freq = w.freq_start_khz;
                  if (table_q[i].high_freq < w.freq_end_khz)
                     table_q[i].high_freq = w.freq_end_khz;
                  if (table_q[i].power < w.power) table_q[i].power = w.power;
                  r = slot_word(rat_pkg::KIND_MERGED, table_q[i]);
               end
            end
         end
         if (!hit && table_q.size() == rat_pkg::SLOTS) begin
            e.id = 0; e.first_time = frame_time; e.last_time = frame_time;
            e.low_freq = w.freq_start_khz; e.high_freq = w.freq_end_khz;
            e.power = w.power;
            r = slot_word(rat_pkg::KIND_FULL, e);
         end else if (!hit) begin
            e.id = next_id; next_id = next_id + 1;
            e.first_time = frame_time; e.last_time = frame_time;
            e.low_freq = w.freq_start_khz; e.high_freq = w.freq_end_khz;
            e.power = w.power;
            table_q = {table_q, e};
            r = slot_word(rat_pkg::KIND_CREATED, e);
         end
         r.last = 1'b1;
         expected_words = {expected_words, r};
      end else if (w.mode == rat_pkg::MODE_RETIRE) begin
         foreach (table_q[i]) begin
            if (frame_time - table_q[i].last_time > {32'd0, end_delay})
               expected_words = {expected_words, slot_word(
                  (table_q[i].last_time - table_q[i].first_time < {32'd0, min_length})
                  ? rat_pkg::KIND_SHORT : rat_pkg::KIND_FINISHED, table_q[i])};
            else
               kept = {kept, table_q[i]};
         end
         table_q = kept;
         r = '0;
         r.kind = rat_pkg::KIND_DONE;
         r.last = 1'b1;
         expected_words = {expected_words, r};
         frame_time = '0;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the accepting edge.
   task automatic send_word(rat_pkg::req_type w);
      while (send_gap > 0 && $urandom_range(99) < send_gap) begin
         start <= 1'b0;
         @(negedge clock);
      end
      while (busy) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req <= w;
      start <= 1'b1;
      @(negedge clock);
      track_word(w);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] v);
      drain();
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == rat_pkg::CSR_END_DELAY) end_delay = v; else min_length = v;
   endtask

   function automatic rat_pkg::req_type make_word(logic [1:0] m, logic [63:0] t,
                                                  logic [31:0] lo, logic [31:0] hi,
                                                  logic [7:0] p);
      rat_pkg::req_type w;
      w.mode = m; w.time_ns = t; w.freq_start_khz = lo; w.freq_end_khz = hi;
      w.power = p;
      return w;
   endfunction

   task automatic test_directed();
      send_word(make_word(rat_pkg::MODE_DETECT, '1, 32'd1000, 32'd2000, 8'h80));
      send_word(make_word(rat_pkg::MODE_START, 64'd5000, '0, '0, '0));
      send_word(make_word(rat_pkg::MODE_DETECT, '0, 32'd1000, 32'd2000, 8'h7f));
      send_word(make_word(rat_pkg::MODE_DETECT, '0, 32'd1040, 32'd1900, 8'h10));
      send_word(make_word(rat_pkg::MODE_DETECT, '0, 32'd5, 32'd5, 8'h00));
      send_word(make_word(rat_pkg::MODE_DETECT, '0, '1, '0, 8'hff));
      send_word(make_word(rat_pkg::MODE_DETECT, '0, '0, '1, 8'h01));
      send_word(make_word(2'd3, '1, '1, '1, 8'hff));
      send_word(make_word(rat_pkg::MODE_RETIRE, '0, '0, '0, '0));
      send_word(make_word(rat_pkg::MODE_START, '1, '0, '0, '0));
      send_word(make_word(rat_pkg::MODE_RETIRE, '0, '0, '0, '0));
      send_word(make_word(rat_pkg::MODE_START, 64'd100, '0, '0, '0));
      for (int i = 0; i < rat_pkg::SLOTS + 2; i++)
         send_word(make_word(rat_pkg::MODE_DETECT, '0, i * 32'h100000,
            i * 32'h100000 + 32'd1000, i[7:0]));
      send_word(make_word(rat_pkg::MODE_START, 64'd900, '0, '0, '0));
      send_word(make_word(rat_pkg::MODE_RETIRE, '0, '0, '0, '0));
      drain();
   endtask

   task automatic test_random(int count, int gap);
      logic [31:0] lo, hi;
      int pick;
      send_gap = gap;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         lo = $urandom_range(40) * 32'h0400_0000 + $urandom_range(3000);
         hi = lo + $urandom_range(4000, 100);
         if (pick < 5) begin
            lo = $urandom; hi = $urandom;
         end
         if (pick < 8)
            send_word(make_word(rat_pkg::MODE_START, {$urandom, $urandom}, $urandom,
               $urandom, 8'($urandom)));
         else if (pick < 16)
            send_word(make_word(rat_pkg::MODE_START, 64'd1000 * i + $urandom_range(3000),
               '0, '0, '0));
         else if (pick < 24)
            send_word(make_word(rat_pkg::MODE_RETIRE, {$urandom, $urandom}, '0, '0, '0));
         else if (pick < 26)
            send_word(make_word(2'd3, {$urandom, $urandom}, $urandom, $urandom,
               8'($urandom)));
         else
            send_word(make_word(rat_pkg::MODE_DETECT, {$urandom, $urandom}, lo, hi,
               8'($urandom)));
      end
      send_gap = 0;
   endtask

   initial begin
      table_q = {};
      next_id = '0; frame_time = '0; end_delay = '0; min_length = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      write_reg(rat_pkg::CSR_END_DELAY, 32'd0);
      write_reg(rat_pkg::CSR_MIN_LENGTH, '1);
      test_random(15, 0);
      write_reg(rat_pkg::CSR_END_DELAY, 32'd2500);
      write_reg(rat_pkg::CSR_MIN_LENGTH, 32'd1500);
      test_random(15, 63);
      write_reg(rat_pkg::CSR_END_DELAY, '1);
      write_reg(rat_pkg::CSR_MIN_LENGTH, 32'd0);
      test_random(12, 14);
      write_reg(rat_pkg::CSR_END_DELAY, 32'd800);
      test_random(12, 0);
      send_word(make_word(rat_pkg::MODE_RETIRE, '0, '0, '0, '0));
      drain();
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
